/* rtl/ppp_pkg.sv */
`default_nettype none

package ppp_pkg;

    localparam int FRAC_BITS = 16;

    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 4'd3;

    localparam logic [31:0] FOCAL_X_RST  = 32'd34406400;
    localparam logic [31:0] FOCAL_Y_RST  = 32'd34406400;
    localparam logic [31:0] CENTER_X_RST = 32'd20971520;
    localparam logic [31:0] CENTER_Y_RST = 32'd15728640;

    // -1.0 pixel in fixed point
    localparam logic [31:0] SENTINEL = ~((32'd1 << FRAC_BITS) - 32'd1);

    // one quotient bit per divider stage; a quotient of 2^33 or more always saturates
    localparam int Q_BITS    = 33;
    localparam int DIV_STEPS = Q_BITS;

    localparam logic [33:0] Q_CLAMP = 34'h2_0000_0000;
    localparam logic signed [35:0] SUM_MAX = 36'sh0_7FFF_FFFF;
    localparam logic signed [35:0] SUM_MIN = -36'sh0_8000_0000;

    typedef struct packed {
        logic [31:0]       rem;
        logic [Q_BITS-1:0] dvd;
        logic [Q_BITS-1:0] quo;
        logic              ovf;
        logic              neg;
    } axis_t;

    typedef struct packed {
        logic        zero;
        logic [31:0] dm;
        axis_t       ax_u;
        axis_t       ax_v;
    } stage_t;

    typedef struct packed {
        logic [31:0] u;
        logic [31:0] v;
        logic        ok;
    } result_t;

endpackage

`default_nettype wire

/* rtl/ppp_front.sv */
`default_nettype none

module ppp_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire logic            in_valid,
    input  wire logic [31:0]     point_x,
    input  wire logic [31:0]     point_y,
    input  wire logic [31:0]     point_z,
    input  wire logic [31:0]     focal_x,
    input  wire logic [31:0]     focal_y,
    output logic                 vld,
    output ppp_pkg::stage_t      d_out
);

    localparam int Q_HI = ppp_pkg::Q_BITS;

    typedef struct packed {
        logic [31:0] ax;
        logic [31:0] ay;
        logic [31:0] az;
        logic        neg_u;
        logic        neg_v;
        logic        zero;
    } abs_t;

    typedef struct packed {
        logic [63:0] pu;
        logic [63:0] pv;
        logic [31:0] dm;
        logic        neg_u;
        logic        neg_v;
        logic        zero;
    } prod_t;

    logic            s1_vld_reg;
    abs_t            s1_reg;
    abs_t            s1_next;
    logic            s2_vld_reg;
    prod_t           s2_reg;
    prod_t           s2_next;
    logic            s3_vld_reg;
    ppp_pkg::stage_t s3_reg;
    ppp_pkg::stage_t s3_next;
    logic [31:0]     hi_u;
    logic [31:0]     hi_v;

    // stage 1: magnitudes and signs
    always_comb
    begin
        s1_next.ax    = point_x[31] ? (32'd0 - point_x) : point_x;
        s1_next.ay    = point_y[31] ? (32'd0 - point_y) : point_y;
        s1_next.az    = point_z[31] ? (32'd0 - point_z) : point_z;
        s1_next.neg_u = point_x[31] ^ point_z[31];
        s1_next.neg_v = point_y[31] ^ point_z[31];
        s1_next.zero  = (point_z == 32'd0);
    end

    // stage 2: exact products focal * |coord|
    always_comb
    begin
        s2_next.pu    = {32'd0, focal_x} * {32'd0, s1_reg.ax};
        s2_next.pv    = {32'd0, focal_y} * {32'd0, s1_reg.ay};
        s2_next.dm    = s1_reg.az;
        s2_next.neg_u = s1_reg.neg_u;
        s2_next.neg_v = s1_reg.neg_v;
        s2_next.zero  = s1_reg.zero;
    end

    // stage 3: high bits beyond the quotient range decide overflow, rest seeds divider
    assign hi_u = {1'b0, s2_reg.pu[63:Q_HI]};
    assign hi_v = {1'b0, s2_reg.pv[63:Q_HI]};

    always_comb
    begin
        s3_next.zero     = s2_reg.zero;
        s3_next.dm       = s2_reg.dm;
        s3_next.ax_u.rem = hi_u;
        s3_next.ax_u.dvd = s2_reg.pu[Q_HI-1:0];
        s3_next.ax_u.quo = '0;
        s3_next.ax_u.ovf = (hi_u >= s2_reg.dm);
        s3_next.ax_u.neg = s2_reg.neg_u;
        s3_next.ax_v.rem = hi_v;
        s3_next.ax_v.dvd = s2_reg.pv[Q_HI-1:0];
        s3_next.ax_v.quo = '0;
        s3_next.ax_v.ovf = (hi_v >= s2_reg.dm);
        s3_next.ax_v.neg = s2_reg.neg_v;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= in_valid;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
        end
    end

    assign vld   = s3_vld_reg;
    assign d_out = s3_reg;

endmodule

`default_nettype wire

/* rtl/ppp_div_step.sv */
`default_nettype none

module ppp_div_step (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic             vld_in,
    input  wire ppp_pkg::stage_t  d_in,
    output logic                  vld_out,
    output ppp_pkg::stage_t       d_out
);

    logic            vld_reg;
    ppp_pkg::stage_t d_reg;
    ppp_pkg::stage_t d_next;

    // one restoring step: bring in the next dividend bit, subtract if it fits
    function automatic ppp_pkg::axis_t step(input ppp_pkg::axis_t a, input logic [31:0] dm);
        logic [32:0]    t;
        logic [32:0]    diff;
        logic           ge;
        ppp_pkg::axis_t r;
        t     = {a.rem, a.dvd[ppp_pkg::Q_BITS-1]};
        diff  = t - {1'b0, dm};
        ge    = (t >= {1'b0, dm});
        r     = a;
        r.rem = ge ? diff[31:0] : t[31:0];
        r.dvd = {a.dvd[ppp_pkg::Q_BITS-2:0], 1'b0};
        r.quo = {a.quo[ppp_pkg::Q_BITS-2:0], ge};
        return r;
    endfunction

    always_comb
    begin
        d_next      = d_in;
        d_next.ax_u = step(d_in.ax_u, d_in.dm);
        d_next.ax_v = step(d_in.ax_v, d_in.dm);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
        end
    end

    assign vld_out = vld_reg;
    assign d_out   = d_reg;

endmodule

`default_nettype wire

/* rtl/ppp_back.sv */
`default_nettype none

module ppp_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic             vld_in,
    input  wire ppp_pkg::stage_t  d_in,
    input  wire logic [31:0]      center_x,
    input  wire logic [31:0]      center_y,
    output logic                  vld_out,
    output ppp_pkg::result_t      res
);

    typedef struct packed {
        logic [33:0] qu;
        logic [33:0] qv;
        logic        neg_u;
        logic        neg_v;
        logic        zero;
    } round_t;

    logic   r_vld_reg;
    round_t r_reg;
    round_t r_next;

    // round half away from zero on the magnitude, clamp where the sum saturates anyway
    function automatic logic [33:0] round_q(input ppp_pkg::axis_t a, input logic [31:0] dm);
        logic inc;
        inc = ({a.rem, 1'b0} >= {1'b0, dm});
        return a.ovf ? ppp_pkg::Q_CLAMP : ({1'b0, a.quo} + {33'd0, inc});
    endfunction

    function automatic logic [31:0] add_sat(input logic [33:0] q, input logic neg,
                                            input logic [31:0] c);
        logic signed [35:0] s;
        logic [31:0]        r;
        s = neg ? (signed'({4'd0, c}) - signed'({2'd0, q}))
                : (signed'({4'd0, c}) + signed'({2'd0, q}));
        if (s > ppp_pkg::SUM_MAX)
            r = 32'h7FFF_FFFF;
        else if (s < ppp_pkg::SUM_MIN)
            r = 32'h8000_0000;
        else
            r = s[31:0];
        return r;
    endfunction

    always_comb
    begin
        r_next.qu    = round_q(d_in.ax_u, d_in.dm);
        r_next.qv    = round_q(d_in.ax_v, d_in.dm);
        r_next.neg_u = d_in.ax_u.neg;
        r_next.neg_v = d_in.ax_v.neg;
        r_next.zero  = d_in.zero;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            r_vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg <= r_next;
        end
    end

    // center add and saturation feed the output register directly
    always_comb
    begin
        if (r_reg.zero)
        begin
            res.u  = ppp_pkg::SENTINEL;
            res.v  = ppp_pkg::SENTINEL;
            res.ok = 1'b0;
        end
        else
        begin
            res.u  = add_sat(r_reg.qu, r_reg.neg_u, center_x);
            res.v  = add_sat(r_reg.qv, r_reg.neg_v, center_y);
            res.ok = 1'b1;
        end
    end

    assign vld_out = r_vld_reg;

endmodule

`default_nettype wire

/* rtl/pinhole_point_projection_unit.sv */
// pipeline: 38 stages from an accepted input beat to its result on the output
// register (3 front, 33 one-bit divider, 1 rounding, output)
// throughput: one point per cycle while the skid is empty (divider fully pipelined)
// reset: clears all valid bits, including those of the output and skid registers,
// and loads the default intrinsics (fx = fy = 525.0, cx = 320.0, cy = 240.0)
`default_nettype none

module pinhole_point_projection_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [31:0]            point_x,
    input  wire logic signed [31:0]            point_y,
    input  wire logic signed [31:0]            point_z,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [31:0]                 pixel_u,
    output logic signed [31:0]                 pixel_v,
    output logic                               point_valid,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [ppp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]                   cfg_data
);

    logic [31:0] focal_x_reg;
    logic [31:0] focal_y_reg;
    logic [31:0] center_x_reg;
    logic [31:0] center_y_reg;

    logic              en;
    logic              front_vld;
    ppp_pkg::stage_t   front_d;
    logic              div_vld [ppp_pkg::DIV_STEPS+1];
    ppp_pkg::stage_t   div_d   [ppp_pkg::DIV_STEPS+1];
    logic              pipe_vld;
    ppp_pkg::result_t  pipe_res;

    logic              out_vld_reg;
    ppp_pkg::result_t  out_reg;
    logic              skid_vld_reg;
    ppp_pkg::result_t  skid_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_x_reg  <= ppp_pkg::FOCAL_X_RST;
            focal_y_reg  <= ppp_pkg::FOCAL_Y_RST;
            center_x_reg <= ppp_pkg::CENTER_X_RST;
            center_y_reg <= ppp_pkg::CENTER_Y_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ppp_pkg::REG_FOCAL_X:  focal_x_reg  <= cfg_data;
                ppp_pkg::REG_FOCAL_Y:  focal_y_reg  <= cfg_data;
                ppp_pkg::REG_CENTER_X: center_x_reg <= cfg_data;
                ppp_pkg::REG_CENTER_Y: center_y_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // the whole pipeline moves unless the skid holds a beat
    assign en       = !skid_vld_reg;
    assign in_ready = en;

    ppp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_valid),
        .point_x  (point_x),
        .point_y  (point_y),
        .point_z  (point_z),
        .focal_x  (focal_x_reg),
        .focal_y  (focal_y_reg),
        .vld      (front_vld),
        .d_out    (front_d)
    );

    assign div_vld[0] = front_vld;
    assign div_d[0]   = front_d;

    for (genvar i = 0; i < ppp_pkg::DIV_STEPS; i++)
    begin : g_div
        ppp_div_step u_step (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .vld_in  (div_vld[i]),
            .d_in    (div_d[i]),
            .vld_out (div_vld[i+1]),
            .d_out   (div_d[i+1])
        );
    end

    ppp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vld_in   (div_vld[ppp_pkg::DIV_STEPS]),
        .d_in     (div_d[ppp_pkg::DIV_STEPS]),
        .center_x (center_x_reg),
        .center_y (center_y_reg),
        .vld_out  (pipe_vld),
        .res      (pipe_res)
    );

    // output register with one skid entry behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (skid_vld_reg)
        begin
            if (out_ready)
            begin
                skid_vld_reg <= 1'b0;
            end
        end
        else if (pipe_vld)
        begin
            if (!out_vld_reg || out_ready)
            begin
                out_vld_reg <= 1'b1;
            end
            else
            begin
                skid_vld_reg <= 1'b1;
            end
        end
        else if (out_ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_vld_reg)
        begin
            if (out_ready)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (pipe_vld)
        begin
            if (!out_vld_reg || out_ready)
            begin
                out_reg <= pipe_res;
            end
            else
            begin
                skid_reg <= pipe_res;
            end
        end
    end

    assign out_valid   = out_vld_reg;
    assign pixel_u     = out_reg.u;
    assign pixel_v     = out_reg.v;
    assign point_valid = out_reg.ok;

    a_skid_needs_out : assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid holds a beat while the output register is empty");

    a_skid_on_stall : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_vld_reg) |-> $past(out_vld_reg && !out_ready))
        else $error("skid filled without an output stall");

    a_empty_sentinel : assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !point_valid) |->
            (pixel_u == ppp_pkg::SENTINEL && pixel_v == ppp_pkg::SENTINEL))
        else $error("empty point without sentinel coordinates");

    a_frozen_on_skid : assert property (@(posedge clk) disable iff (!rst_n)
        (skid_vld_reg && $past(skid_vld_reg)) |-> $stable(pipe_vld))
        else $error("pipeline moved while the skid was full");

endmodule

`default_nettype wire

/* bench/tb_pinhole_point_projection_unit.sv */
`timescale 1ns / 1ps

module tb_pinhole_point_projection_unit;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 45;
    localparam int HOLD_CYCLES    = 400;
    localparam int REPORT_LIMIT   = 10;
    localparam int INDEX_SPAN     = 1 << ppp_pkg::CFG_IDX_W;

    localparam logic [ppp_pkg::CFG_IDX_W-1:0] REG_COUNT = ppp_pkg::REG_CENTER_Y + 1'b1;
    localparam logic [63:0]          QUOT_CAP  = 64'd1 << 40;
    localparam longint               PIX_MAX   = 64'sd2147483647;
    localparam longint               PIX_MIN   = -64'sd2147483648;
    localparam logic signed [31:0]   EMPTY_PIXEL = -(32'sd1 << ppp_pkg::FRAC_BITS);
    localparam logic signed [31:0]   INT_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [31:0]   INT_MIN   = 32'sh8000_0000;
    localparam logic signed [31:0]   ONE       = 32'sd1 << ppp_pkg::FRAC_BITS;
    localparam logic [15:0]          RX_PATTERN_BITS = 16'b1101_0011_1011_0110;

    typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

    typedef struct packed {
        logic signed [31:0] u;
        logic signed [31:0] v;
        logic               hit;
    } pixel_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_ready;
    logic signed [31:0]          point_x = '0;
    logic signed [31:0]          point_y = '0;
    logic signed [31:0]          point_z = '0;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    logic signed [31:0]          pixel_u;
    logic signed [31:0]          pixel_v;
    logic                        point_valid;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [ppp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]                 cfg_data = '0;

    // intrinsics as the block should currently hold them
    logic [31:0] cam_fx = ppp_pkg::FOCAL_X_RST;
    logic [31:0] cam_fy = ppp_pkg::FOCAL_Y_RST;
    logic [31:0] cam_cx = ppp_pkg::CENTER_X_RST;
    logic [31:0] cam_cy = ppp_pkg::CENTER_Y_RST;

    pixel_t   pending_pixels[$];
    pixel_t   rx_want;
    rx_mode_t rx_mode = RX_ALWAYS;
    logic     rx_hold = 1'b0;
    logic [3:0] rx_phase = '0;
    int       quiet_cycles = 0;
    int       error_count = 0;
    int       points_sent = 0;
    int       empty_sent = 0;
    int       results_seen = 0;
    int       cfg_writes = 0;

    pinhole_point_projection_unit DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .point_x     (point_x),
        .point_y     (point_y),
        .point_z     (point_z),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_u     (pixel_u),
        .pixel_v     (pixel_v),
        .point_valid (point_valid),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic void flag_error(input string msg);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("ERROR at %0t: %s", $realtime, msg);
    endfunction

    function automatic void queue_pixel(input pixel_t p);
        pending_pixels.insert(pending_pixels.size(), p);
    endfunction

    // focal * coord / depth rounded half away from zero, plus center, clamped to int32
    function automatic logic signed [31:0] project_axis_fixed(input logic [31:0] focal,
            input logic signed [31:0] coord, input logic signed [31:0] depth,
            input logic [31:0] center);
        longint      prod;
        longint      quot_s;
        longint      total;
        logic [63:0] pmag;
        logic [63:0] dmag;
        logic [63:0] quot;
        logic [63:0] rem;
        logic        flip;
        prod = longint'({32'd0, focal}) * longint'(coord);
        flip = (prod < 0) != (depth < 0);
        pmag = (prod < 0) ? -prod : prod;
        dmag = (depth < 0) ? -longint'(depth) : longint'(depth);
        quot = pmag / dmag;
        rem  = pmag % dmag;
        if ((rem << 1) >= dmag)
            quot++;
        if (quot > QUOT_CAP)
            quot = QUOT_CAP;
        quot_s = flip ? -longint'(quot) : longint'(quot);
        total  = quot_s + longint'({32'd0, center});
        if (total > PIX_MAX)
            total = PIX_MAX;
        if (total < PIX_MIN)
            total = PIX_MIN;
        return total[31:0];
    endfunction

    function automatic pixel_t project_point(input logic signed [31:0] x, y, z);
        pixel_t p;
        if (z == 0)
        begin
            p.u   = EMPTY_PIXEL;
            p.v   = EMPTY_PIXEL;
            p.hit = 1'b0;
        end
        else
        begin
            p.u   = project_axis_fixed(cam_fx, x, z, cam_cx);
            p.v   = project_axis_fixed(cam_fy, y, z, cam_cy);
            p.hit = 1'b1;
        end
        return p;
    endfunction

    task automatic send_point(input logic signed [31:0] x, y, z);
        in_valid <= 1'b1;
        point_x  <= x;
        point_y  <= y;
        point_z  <= z;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        queue_pixel(project_point(x, y, z));
        points_sent++;
        if (z == 0)
            empty_sent++;
    endtask

    task automatic write_reg(input logic [ppp_pkg::CFG_IDX_W-1:0] idx,
            input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            ppp_pkg::REG_FOCAL_X:  cam_fx = data;
            ppp_pkg::REG_FOCAL_Y:  cam_fy = data;
            ppp_pkg::REG_CENTER_X: cam_cx = data;
            ppp_pkg::REG_CENTER_Y: cam_cy = data;
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic load_intrinsics(input logic [31:0] fx, fy, cx, cy);
        write_reg(ppp_pkg::REG_FOCAL_X, fx);
        write_reg(ppp_pkg::REG_FOCAL_Y, fy);
        write_reg(ppp_pkg::REG_CENTER_X, cx);
        write_reg(ppp_pkg::REG_CENTER_Y, cy);
        cfg_valid <= 1'b0;
    endtask

    // every point yields a result, so an empty queue means the pipe is idle
    task automatic wait_for_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_pixels.size() != 0);
    endtask

    task automatic random_point(output logic signed [31:0] x, y, z);
        case ($urandom_range(0, 9))
            0, 1:
            begin
                x = $urandom;
                y = $urandom;
                z = $urandom;
            end
            2:
            begin
                x = $urandom;
                y = $urandom;
                z = '0;
            end
            3:
            begin
                // tiny depth drives the quotient into saturation
                x = $urandom;
                y = $urandom;
                z = $urandom_range(1, 64);
                if ($urandom_range(0, 1))
                    z = -z;
            end
            default:
            begin
                x = int'($urandom_range(0, 40 << ppp_pkg::FRAC_BITS))
                    - (20 << ppp_pkg::FRAC_BITS);
                y = int'($urandom_range(0, 40 << ppp_pkg::FRAC_BITS))
                    - (20 << ppp_pkg::FRAC_BITS);
                z = $urandom_range(1 << (ppp_pkg::FRAC_BITS - 2), 50 << ppp_pkg::FRAC_BITS);
                if ($urandom_range(0, 9) == 0)
                    z = -z;
            end
        endcase
    endtask

    task automatic stream_points(input int count, input int gap_max);
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        int                 left;
        int                 burst;
        left = count;
        while (left > 0)
        begin
            burst = $urandom_range(1, 24);
            if (burst > left)
                burst = left;
            left -= burst;
            repeat (burst)
            begin
                random_point(x, y, z);
                send_point(x, y, z);
            end
            if (gap_max > 0 && left > 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, gap_max))
                    @(posedge clk);
            end
        end
    endtask

    function automatic logic [31:0] real_focal();
        return ($urandom_range(200, 1500) << ppp_pkg::FRAC_BITS)
            | $urandom_range(0, (1 << ppp_pkg::FRAC_BITS) - 1);
    endfunction

    function automatic logic [31:0] real_center();
        return $urandom_range(0, 1920 << ppp_pkg::FRAC_BITS);
    endfunction

    task automatic test_directed_defaults();
        send_point(0, 0, ONE);
        send_point(ONE, -ONE, ONE);
        send_point(5, 5, 0);
        send_point(INT_MIN, INT_MIN, 0);
        send_point(ONE, ONE, -ONE);
        send_point(INT_MAX, INT_MIN, 1);
        send_point(INT_MIN, INT_MAX, -1);
        send_point(INT_MAX, INT_MAX, INT_MAX);
        send_point(INT_MIN, INT_MIN, INT_MIN);
        // focal / (2 * focal) lands exactly on a half: rounds away from zero
        send_point(1, -1, 2 * ppp_pkg::FOCAL_X_RST);
        send_point(-3, 3, 2 * ppp_pkg::FOCAL_X_RST);
        send_point(-1, -1, -1);
    endtask

    task automatic test_register_extremes();
        wait_for_results();
        load_intrinsics('1, 32'd1, '0, '1);
        send_point(INT_MIN, INT_MAX, 1);
        send_point(INT_MAX, INT_MIN, INT_MIN);
        send_point(1, 1, INT_MAX);
        send_point(0, 0, 0);
        send_point(-1, -(1 << 20), 3);
        // zero focal collapses every projection with nonzero depth onto the center
        wait_for_results();
        load_intrinsics('0, '0, 100 << ppp_pkg::FRAC_BITS, '0);
        send_point(INT_MAX, INT_MIN, 7);
        send_point(5, 5, 0);
    endtask

    task automatic test_ignored_indexes();
        wait_for_results();
        for (int i = REG_COUNT; i < INDEX_SPAN; i++)
            write_reg(i[ppp_pkg::CFG_IDX_W-1:0], $urandom);
        cfg_valid <= 1'b0;
        send_point(ONE, ONE, ONE);
        send_point(-ONE, 3 * ONE, 2 * ONE);
    endtask

    task automatic test_backpressure();
        wait_for_results();
        load_intrinsics(ppp_pkg::FOCAL_X_RST, ppp_pkg::FOCAL_Y_RST,
            ppp_pkg::CENTER_X_RST, ppp_pkg::CENTER_Y_RST);
        rx_mode <= RX_ALWAYS;
        fork
            begin
                rx_hold <= 1'b1;
                repeat (HOLD_CYCLES)
                    @(posedge clk);
                rx_hold <= 1'b0;
            end
            stream_points(150, 0);
        join
    endtask

    task automatic test_random_traffic();
        wait_for_results();
        rx_mode <= RX_RANDOM;
        load_intrinsics(ppp_pkg::FOCAL_X_RST, ppp_pkg::FOCAL_Y_RST,
            ppp_pkg::CENTER_X_RST, ppp_pkg::CENTER_Y_RST);
        stream_points(400, 6);

        wait_for_results();
        rx_mode <= RX_PATTERN;
        load_intrinsics(real_focal(), real_focal(), real_center(), real_center());
        stream_points(400, 3);

        // no idling on either side
        wait_for_results();
        rx_mode <= RX_ALWAYS;
        load_intrinsics($urandom, $urandom, $urandom, $urandom);
        stream_points(350, 0);

        wait_for_results();
        rx_mode <= RX_RANDOM;
        load_intrinsics(real_focal(), real_focal(), real_center(), real_center());
        stream_points(400, 10);

        wait_for_results();
        rx_mode <= RX_PATTERN;
        load_intrinsics(32'd1, 32'd1, '0, '0);
        stream_points(200, 4);
    endtask

    always @(posedge clk)
    begin
        rx_phase <= rx_phase + 1'b1;
        if (rx_hold)
            out_ready <= 1'b0;
        else
            case (rx_mode)
                RX_ALWAYS:  out_ready <= 1'b1;
                RX_RANDOM:  out_ready <= ($urandom_range(0, 3) != 0);
                RX_PATTERN: out_ready <= RX_PATTERN_BITS[rx_phase];
                default:    out_ready <= 1'b1;
            endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_pixels.size() == 0)
                flag_error($sformatf("unexpected result beat: u=%0d v=%0d valid=%0b",
                    pixel_u, pixel_v, point_valid));
            else
            begin
                rx_want = pending_pixels.pop_front();
                if (pixel_u !== rx_want.u || pixel_v !== rx_want.v
                        || point_valid !== rx_want.hit)
                    flag_error($sformatf(
                        "beat %0d: expected u=%0d v=%0d valid=%0b, got u=%0d v=%0d valid=%0b",
                        results_seen, rx_want.u, rx_want.v, rx_want.hit,
                        pixel_u, pixel_v, point_valid));
                results_seen++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no beat accepted for %0d cycles, %0d results outstanding",
                quiet_cycles, pending_pixels.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        test_directed_defaults();
        test_register_extremes();
        test_ignored_indexes();
        test_backpressure();
        test_random_traffic();
        wait_for_results();
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (pending_pixels.size() != 0)
            flag_error($sformatf("%0d results never arrived", pending_pixels.size()));
        $display("projected %0d points (%0d with zero depth), checked %0d results, %0d reg writes",
            points_sent, empty_sent, results_seen, cfg_writes);
        $display("output side ran always-ready, random, patterned and a %0d-cycle hold-off",
            HOLD_CYCLES);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
